// ----- src/taylor_sine_approximator_core_assert.svh -----
// assertion macros shared by the rtl
`ifndef TAYLOR_SINE_APPROXIMATOR_CORE_ASSERT_SVH
`define TAYLOR_SINE_APPROXIMATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TSA_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tsa assertion failed");

// next-cycle implication
`define TSA_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tsa assertion failed");

`else

`define TSA_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define TSA_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- src/tsa_pkg.sv -----
package tsa_pkg;

  // working format
  localparam int FRAC_BITS_DEFAULT = 32;
  localparam int ANGLE_FRAC        = 28;

  // field widths
  localparam int ANGLE_W  = 32;
  localparam int SUM_W    = 64;
  localparam int TERMS_W  = 8;
  localparam int DIFF_W   = 63;
  localparam int MAG_W    = 63;
  localparam int TOL_W    = 33;

  // divisor (2n)(2n+1) stays below 2^18 for n up to 255
  localparam int DIV_W    = 18;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 33;

  localparam logic [TOL_W-1:0]   TOL_RESET  = 33'd4294967;
  localparam logic [TERMS_W-1:0] MAXT_RESET = 8'd101;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOLERANCE,
    REG_MAX_TERMS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVSET,
    S_DIV,
    S_SUM,
    S_CHECK,
    S_FINISH
  } state_t;

endpackage

// ----- src/tsa_operand_if.sv -----
interface tsa_operand_if;
  import tsa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// ----- src/tsa_result_if.sv -----
interface tsa_result_if;
  import tsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  sine_sum;
  logic [TERMS_W-1:0]       terms_used;
  logic [DIFF_W-1:0]        final_difference;
  logic                     limit_hit;

  modport source (output valid, output sine_sum, output terms_used,
                  output final_difference, output limit_hit, input ready);
  modport sink (input valid, input sine_sum, input terms_used,
                input final_difference, input limit_hit, output ready);
endinterface

// ----- src/taylor_sine_approximator_core.sv -----
// channel    dir  payload                                         handshake
// operand    in   angle (s32, Q4.28)                              valid/ready
// result     out  sine_sum, terms_used, final_difference,         valid/ready
//                 limit_hit
// cfg        in   cfg_index, cfg_data                             cfg_write
//
// one request at a time; each new term passes through the shared 32x32
// multiplier, a setup step, the radix-2 divider, a sum step and a check step.
// the first term's slot squares the angle instead of dividing a term, and the
// term count has a ceiling of 255. the divider's loop, one quotient bit per
// cycle, sets the pace of each term.
// rst is synchronous; it clears control state and loads the register defaults.
// a waiting result does not block the next request; the core holds in its
// last step only when a second result is ready before the first is taken.
`include "taylor_sine_approximator_core_assert.svh"

module taylor_sine_approximator_core #(
  parameter int FRAC_BITS = tsa_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]   cfg_data,
  tsa_operand_if.sink                      operand,
  tsa_result_if.source                     result
);
  import tsa_pkg::*;

  localparam int SHL = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int SHR = (FRAC_BITS >= ANGLE_FRAC) ? 0 : ANGLE_FRAC - FRAC_BITS;
  localparam int HI_SHIFT = FRAC_BITS + MAG_W;
  localparam logic [SUM_W-1:0] MAG_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  state_t state, state_next;

  // configuration registers
  logic [TOL_W-1:0]   tolerance;
  logic [TERMS_W-1:0] max_terms;

  // series state
  logic [TERMS_W-1:0] limit;
  logic [TERMS_W-1:0] count;
  logic [MAG_W-1:0]   tmag;
  logic               tneg;
  logic [MAG_W-1:0]   x2;
  logic               sq_phase;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   prev;
  logic [SUM_W-1:0]   cur_term;
  logic [SUM_W-1:0]   diff;
  logic               hit;

  // multiplier and divider
  logic [127:0]       acc;
  logic [63:0]        prod;
  logic [1:0]         pp_tag;
  logic [2:0]         pp_idx;
  logic [DIV_W-1:0]   rem;
  logic [MAG_W-1:0]   quo;
  logic [5:0]         bit_cnt;
  logic               sat;
  logic [DIV_W-1:0]   d;
  logic [DIV_W-1:0]   dinc;

  // output register
  logic               out_valid;
  logic [SUM_W-1:0]   out_sum;
  logic [TERMS_W-1:0] out_terms;
  logic [DIFF_W-1:0]  out_diff;
  logic               out_hit;

  logic               accept;
  logic [DIV_W-1:0]   dv;
  logic [31:0]        ang_u;
  logic [31:0]        mag32;
  logic [63:0]        mag_ext;
  logic [63:0]        a_op;
  logic [63:0]        b_op;
  logic [31:0]        a_part;
  logic [31:0]        b_part;
  logic [127:0]       pp_term;
  logic [127:0]       p_hi;
  logic               p_sat;
  logic [DIV_W:0]     r2;
  logic               ge;
  logic [DIV_W:0]     r2_sub;
  logic [MAG_W-1:0]   q_res;
  logic [SUM_W-1:0]   term;
  logic [SUM_W-1:0]   sum_add;
  logic               sum_ovf;
  logic               conv;
  logic               out_free;

  assign accept   = operand.valid && operand.ready;
  assign out_free = !out_valid || result.ready;
  assign dv       = sq_phase ? DIV_W'(1) : d;

  // angle magnitude in the working format
  assign ang_u   = operand.angle;
  assign mag32   = ang_u[31] ? 32'(~ang_u + 32'd1) : ang_u;
  assign mag_ext = (64'(mag32) << SHL) >> SHR;

  // partial product selection
  assign a_op   = {1'b0, tmag};
  assign b_op   = {1'b0, sq_phase ? tmag : x2};
  assign a_part = pp_idx[0] ? a_op[63:32] : a_op[31:0];
  assign b_part = pp_idx[1] ? b_op[63:32] : b_op[31:0];

  always_comb begin
    unique case (pp_tag)
      2'd0:    pp_term = {64'b0, prod};
      2'd1,
      2'd2:    pp_term = {64'b0, prod} << 32;
      default: pp_term = {64'b0, prod} << 64;
    endcase
  end

  // saturation test: quotient reaches 2^63 when the top part is at least the divisor
  assign p_hi  = acc >> HI_SHIFT;
  assign p_sat = p_hi >= 128'(dv);

  // one restoring divide step
  assign r2     = {rem, quo[MAG_W-1]};
  assign ge     = r2 >= {1'b0, dv};
  assign r2_sub = r2 - {1'b0, dv};
  assign q_res  = sat ? MAG_MAX[MAG_W-1:0] : {quo[MAG_W-2:0], ge};

  // term, saturating sum and convergence
  assign term    = tneg ? SUM_W'(~{1'b0, tmag} + 64'd1) : {1'b0, tmag};
  assign sum_add = sum + term;
  assign sum_ovf = ~(sum[SUM_W-1] ^ term[SUM_W-1]) & (sum[SUM_W-1] ^ sum_add[SUM_W-1]);
  assign conv    = diff <= SUM_W'(tolerance);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    operand.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        operand.ready = 1'b1;
        if (operand.valid) state_next = S_MUL;
      end
      S_MUL: begin
        if (pp_idx == 3'd4) state_next = S_DIVSET;
      end
      S_DIVSET: state_next = S_DIV;
      S_DIV: begin
        if (bit_cnt == 6'(MAG_W - 1)) state_next = S_SUM;
      end
      S_SUM: state_next = S_CHECK;
      S_CHECK: begin
        if (conv || count >= limit) state_next = S_FINISH;
        else state_next = S_MUL;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_terms <= MAXT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        REG_MAX_TERMS: max_terms <= cfg_data[TERMS_W-1:0];
        default: ;
      endcase
    end
  end

  // series datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          tmag     <= mag_ext[MAG_W-1:0];
          tneg     <= ang_u[31];
          sq_phase <= 1'b1;
          sum      <= '0;
          prev     <= '0;
          count    <= '0;
          d        <= DIV_W'(6);
          dinc     <= DIV_W'(14);
          limit    <= (max_terms == '0) ? TERMS_W'(1) : max_terms;
          pp_idx   <= '0;
          acc      <= '0;
        end
      end
      S_MUL: begin
        if (pp_idx != 3'd4) begin
          prod   <= 64'(a_part) * 64'(b_part);
          pp_tag <= pp_idx[1:0];
        end
        if (pp_idx != 3'd0) acc <= acc + pp_term;
        pp_idx <= pp_idx + 3'd1;
      end
      S_DIVSET: begin
        sat     <= p_sat;
        rem     <= p_sat ? '0 : p_hi[DIV_W-1:0];
        quo     <= acc[FRAC_BITS +: MAG_W];
        bit_cnt <= '0;
      end
      S_DIV: begin
        rem     <= ge ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];
        quo     <= {quo[MAG_W-2:0], ge};
        bit_cnt <= bit_cnt + 6'd1;
        if (bit_cnt == 6'(MAG_W - 1)) begin
          if (sq_phase) begin
            x2       <= q_res;
            sq_phase <= 1'b0;
          end else begin
            tmag <= q_res;
            tneg <= ~tneg;
            d    <= d + dinc;
            dinc <= dinc + DIV_W'(8);
          end
        end
      end
      S_SUM: begin
        sum      <= sum_ovf ? (sum[SUM_W-1] ? NEG_MIN : MAG_MAX) : sum_add;
        count    <= count + TERMS_W'(1);
        cur_term <= term;
        diff     <= ($signed(term) >= $signed(prev)) ? term - prev : prev - term;
      end
      S_CHECK: begin
        hit <= !conv && count >= limit;
        if (!conv && count < limit) begin
          prev   <= cur_term;
          pp_idx <= '0;
          acc    <= '0;
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_sum   <= sum;
      out_terms <= count;
      out_diff  <= diff[SUM_W-1] ? {DIFF_W{1'b1}} : diff[DIFF_W-1:0];
      out_hit   <= hit;
    end
  end

  assign result.valid            = out_valid;
  assign result.sine_sum         = out_sum;
  assign result.terms_used       = out_terms;
  assign result.final_difference = out_diff;
  assign result.limit_hit        = out_hit;

  // checks
  `TSA_ASSERT_IMPLY(a_rem_below_div, clk, rst, state == S_DIV, rem < dv)
  `TSA_ASSERT_IMPLY(a_count_in_limit, clk, rst, state != S_IDLE, count <= limit)
  `TSA_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_MUL && sq_phase)
  `TSA_ASSERT_IMPLY(a_hit_at_limit, clk, rst, state == S_FINISH && hit, count == limit)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tsa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 25_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [TERMS_W-1:0]      terms;
    logic [DIFF_W-1:0]       diff;
    logic                    hit;
  } sine_result_t;

  typedef struct packed {
    logic [TOL_W-1:0]   tol;
    logic [TERMS_W-1:0] maxt;
    logic [ANGLE_W-1:0] angle;
    logic               typed;
    sine_result_t       res;
  } stim_row_t;

  // directed requests; typed rows carry their result, the rest go through the predictor
  localparam stim_row_t DIRECTED [18] = '{
    '{TOL_RESET, MAXT_RESET, 32'h0000_0000, 1'b1, '{64'h0, 8'd1, 63'h0, 1'b0}},
    '{TOL_RESET, MAXT_RESET, 32'h0000_0001, 1'b1, '{64'h10, 8'd1, 63'h10, 1'b0}},
    '{TOL_RESET, MAXT_RESET, 32'hFFFF_FFFF, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFF0, 8'd1, 63'h10, 1'b0}},
    '{TOL_RESET, MAXT_RESET, 32'h7FFF_FFFF, 1'b0, '0},
    '{TOL_RESET, MAXT_RESET, 32'h8000_0000, 1'b0, '0},
    '{TOL_RESET, MAXT_RESET, 32'h1921_FB54, 1'b0, '0},
    '{TOL_RESET, MAXT_RESET, 32'hE6DE_04AC, 1'b0, '0},
    '{TOL_RESET, MAXT_RESET, 32'h1000_0000, 1'b0, '0},
    // zero term limit acts as one
    '{33'd0, 8'd0, 32'h1000_0000, 1'b1,
      '{64'h1_0000_0000, 8'd1, 63'h1_0000_0000, 1'b1}},
    '{33'd0, 8'd1, 32'h7FFF_FFFF, 1'b1,
      '{64'h7_FFFF_FFF0, 8'd1, 63'h7_FFFF_FFF0, 1'b1}},
    // converged and at the limit together: convergence wins
    '{33'h1_FFFF_FFFF, 8'd1, 32'h1FFF_FFFF, 1'b1,
      '{64'h1_FFFF_FFF0, 8'd1, 63'h1_FFFF_FFF0, 1'b0}},
    '{33'h1_FFFF_FFFF, 8'd1, 32'h0000_0000, 1'b1, '{64'h0, 8'd1, 63'h0, 1'b0}},
    // term limits from 2 up to 255
    '{33'd0, 8'd255, 32'h7FFF_FFFF, 1'b0, '0},
    '{33'd0, 8'd255, 32'h8000_0000, 1'b0, '0},
    '{33'd0, 8'd2, 32'h1000_0000, 1'b0, '0},
    '{33'd0, 8'd128, 32'h3243_F6A8, 1'b0, '0},
    '{33'd1, 8'd128, 32'hC000_0000, 1'b0, '0},
    '{TOL_RESET, 8'd3, 32'h5000_0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsa_operand_if operand_ch();
  tsa_result_if result_ch();

  taylor_sine_approximator_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .operand(operand_ch),
    .result(result_ch)
  );

  // predictor copy of the registers
  logic [TOL_W-1:0] tol_reg = TOL_RESET;
  logic [TERMS_W-1:0] maxt_reg = MAXT_RESET;

  sine_result_t pending_sines[$];
  int mismatches = 0;
  int cycles = 0;
  int src_idle_pct = 25;
  int snk_idle_pct = 51;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // (a*b) >> FRAC, divided by d, clamped to the largest magnitude
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] d);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = (128'(a) * 128'(b)) >> FRAC;
    quo = prod / 128'(d);
    return (quo > 128'(MAG_LIMIT)) ? MAG_LIMIT : quo[63:0];
  endfunction

  function automatic logic [63:0] add_saturate(logic [63:0] s, logic [63:0] t);
    logic [63:0] r;
    r = s + t;
    if (s[63] == t[63] && r[63] != s[63])
      return s[63] ? 64'h8000_0000_0000_0000 : MAG_LIMIT;
    return r;
  endfunction

  // series sum for one angle under the current register values
  function automatic sine_result_t taylor_sine(logic [ANGLE_W-1:0] angle);
    logic [31:0] amag;
    logic [63:0] mag, x2, tmag, term, prev, sum, diff, divisor;
    logic [8:0] count;
    logic [8:0] limit;
    logic tneg, hit, done;
    sine_result_t r;
    amag = angle[31] ? -angle : angle;
    mag = {32'd0, amag} << (FRAC - ANGLE_FRAC);
    x2 = scaled_quotient(mag, mag, 64'd1);
    limit = (maxt_reg == 0) ? 9'd1 : {1'b0, maxt_reg};
    tmag = mag;
    tneg = angle[31];
    prev = '0;
    sum = '0;
    diff = '0;
    count = '0;
    hit = 1'b0;
    done = 1'b0;
    while (!done) begin
      term = tneg ? -tmag : tmag;
      sum = add_saturate(sum, term);
      count = count + 9'd1;
      diff = ($signed(term) >= $signed(prev)) ? term - prev : prev - term;
      if (diff <= {31'd0, tol_reg}) begin
        done = 1'b1;
      end else if (count >= limit) begin
        hit = 1'b1;
        done = 1'b1;
      end else begin
        prev = term;
        divisor = 64'(count) << 1;
        divisor = divisor * (divisor + 64'd1);
        tmag = scaled_quotient(tmag, x2, divisor);
        tneg = !tneg;
      end
    end
    r.sum = sum;
    r.terms = count[7:0];
    r.diff = (diff > MAG_LIMIT) ? MAG_LIMIT[62:0] : diff[62:0];
    r.hit = hit;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // one request: random gap, then hold until taken
  task automatic send_angle(logic [ANGLE_W-1:0] angle, logic typed, sine_result_t typed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(negedge clk);
    end
    operand_ch.valid <= 1'b1;
    operand_ch.angle <= angle;
    @(posedge clk);
    while (!operand_ch.ready) @(posedge clk);
    pending_sines.push_back(typed ? typed_res : taylor_sine(angle));
    @(negedge clk);
  endtask

  // drain, then write both registers on back-to-back cycles
  task automatic set_config(logic [TOL_W-1:0] tol, logic [TERMS_W-1:0] maxt);
    operand_ch.valid <= 1'b0;
    while (pending_sines.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_data <= tol;
    @(negedge clk);
    cfg_index <= REG_MAX_TERMS;
    cfg_data <= {{(CFG_DATA_W-TERMS_W){1'b0}}, maxt};
    @(negedge clk);
    cfg_write <= 1'b0;
    tol_reg = tol;
    maxt_reg = maxt;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result check against the oldest pending sine
  always @(posedge clk) begin : result_check
    sine_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_sines.size() == 0) begin
        report_mismatch("result with nothing pending", result_ch.sine_sum, 64'd0);
      end else begin
        want = pending_sines.pop_front();
        if (result_ch.sine_sum !== want.sum)
          report_mismatch("sine_sum", result_ch.sine_sum, want.sum);
        if (result_ch.terms_used !== want.terms)
          report_mismatch("terms_used", 64'(result_ch.terms_used), 64'(want.terms));
        if (result_ch.final_difference !== want.diff)
          report_mismatch("final_difference", 64'(result_ch.final_difference),
                          64'(want.diff));
        if (result_ch.limit_hit !== want.hit)
          report_mismatch("limit_hit", 64'(result_ch.limit_hit), 64'(want.hit));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ANGLE_W-1:0] rand_angle;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    operand_ch.valid = 1'b0;
    operand_ch.angle = '0;
    result_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].tol != tol_reg || DIRECTED[i].maxt != maxt_reg)
        set_config(DIRECTED[i].tol, DIRECTED[i].maxt);
      send_angle(DIRECTED[i].angle, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // random requests over several register settings and idle mixes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(TOL_RESET, MAXT_RESET);
        1: set_config(33'd0, 8'd255);
        2: set_config({1'($urandom_range(1)), 32'($urandom())}, 8'($urandom_range(255)));
        3: set_config(33'd1, 8'd0);
        4: set_config(33'h1_FFFF_FFFF, 8'd128);
        default: set_config(33'($urandom_range(32'hFF_FFFF)), 8'($urandom_range(12, 1)));
      endcase
      src_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 51 : 0;
      snk_idle_pct = (phase < 2) ? 51 : (phase < 4) ? 25 : 0;
      repeat (50) begin
        // full-range bits, spread magnitudes, or within two pi
        case ($urandom_range(2))
          0: rand_angle = $urandom();
          1: rand_angle = $urandom() >> $urandom_range(31);
          default: rand_angle = $urandom_range(32'h6487_ED51);
        endcase
        if (!rand_angle[31] && $urandom_range(1))
          rand_angle = -rand_angle;
        send_angle(rand_angle, 1'b0, '0);
      end
    end

    // drain and let the core settle
    operand_ch.valid <= 1'b0;
    while (pending_sines.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
